// ----- rtl/cbad_pkg.sv -----
// Shared types and constants for the console bus address decoder.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
package cbad_pkg;

   localparam int unsigned BOOT_ROM_BYTES_DEFAULT = 2048;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRAM_ON        = 3'd0,
      CSR_SRAM_WRITABLE  = 3'd1,
      CSR_SRAM_IS_EEPROM = 3'd2,
      CSR_SRAM_FIRST     = 3'd3,
      CSR_SRAM_LAST      = 3'd4,
      CSR_CART_ROM_BYTES = 3'd5,
      CSR_ROM_WRITABLE   = 3'd6,
      CSR_UNUSED         = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      TGT_OPEN    = 5'd0,  TGT_LOCK    = 5'd1,  TGT_SRAM  = 5'd2,  TGT_EEP   = 5'd3,
      TGT_ROM     = 5'd4,  TGT_WRAM    = 5'd5,  TGT_ZRAM  = 5'd6,  TGT_FM    = 5'd7,
      TGT_ZBANK   = 5'd8,  TGT_IO      = 5'd9,  TGT_BUSREQ = 5'd10, TGT_RESET = 5'd11,
      TGT_ROMBANK = 5'd12, TGT_MULTI   = 5'd13, TGT_BOOTSEL = 5'd14, TGT_VDATA = 5'd15,
      TGT_VCTRL   = 5'd16, TGT_HVC     = 5'd17, TGT_VTEST = 5'd18, TGT_PSG   = 5'd19,
      TGT_PAD     = 5'd20, TGT_PROT    = 5'd21, TGT_CONST = 5'd22
   } target_type;

   localparam logic [23:0] VDP_MASK     = 24'hE700E0;
   localparam logic [23:0] VDP_MATCH    = 24'hC00000;
   localparam logic [23:0] ZWIN_LAST    = 24'hA0FFFF;
   localparam logic [23:0] IO_LAST      = 24'hA1001F;
   localparam logic [23:0] CTRL_LAST    = 24'hA1FFFF;
   localparam logic [23:0] BUSREQ_ADDR  = 24'hA11100;
   localparam logic [23:0] RESET_ADDR   = 24'hA11200;
   localparam logic [23:0] BOOTSEL_WORD = 24'hA14100;
   localparam logic [23:0] BOOTSEL_BYTE = 24'hA14101;
   localparam logic [23:0] ROMBANK_WORD = 24'hA130F0;
   localparam logic [23:0] MULTI_LAST   = 24'hA13040;
   localparam logic [23:0] PAD_PORT_A   = 24'h3FFFFE;
   localparam logic [23:0] PAD_PORT_B   = 24'h38FFFE;
   localparam logic [23:0] CONST1_ADDR  = 24'h30FE02;
   localparam logic [7:0]  ZLOCK_PAGE   = 8'h7F;

   typedef struct packed {
      logic        func;
      logic        word_size;
      logic [23:0] bus_address;
      logic [15:0] write_value;
      logic        z80_bus_held;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [23:0] target_offset;
      logic [1:0]  byte_lane;
      logic        replicate_byte;
      logic [15:0] open_bus_mask;
      logic [15:0] local_data;
      logic [15:0] device_write_data;
      logic        lockup;
      logic        pad_reset_pulse;
   } rsp_type;

   typedef struct packed {
      logic        sram_on;
      logic        sram_writable;
      logic        sram_is_eeprom;
      logic [23:0] sram_first;
      logic [23:0] sram_last;
      logic [22:0] cart_rom_bytes;
      logic        rom_writable;
   } cfg_type;

   // One classified beat: the access plus the state it saw at accept time
   typedef struct packed {
      req_type    req;
      logic [7:0] prot_byte;
      logic       pad_present;
      logic       boot_mapped;
   } entry_type;

endpackage

// ----- rtl/cbad_front.sv -----
// Front end: accepts accesses, keeps protection/pad/boot state, snapshots it.
// Depends on cbad_pkg.
`timescale 1ns / 1ps
module cbad_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  cbad_pkg::req_type   req_data,
   input  logic                q_full,
   output logic                req_stall,
   output logic                push,
   output cbad_pkg::entry_type push_entry
);
   logic [7:0] prot_ff [2];
   logic [7:0] prot_in [2];
   logic       pad_ff, pad_in, boot_ff, boot_in;
   logic       wr, ws;
   logic [23:0] a;

   assign req_stall = q_full;
   assign push = req_valid && !q_full;
   assign wr = req_data.func;
   assign ws = req_data.word_size;
   assign a  = req_data.bus_address;

   always_comb begin
      prot_in = prot_ff;
      pad_in  = pad_ff;
      boot_in = boot_ff;
      if (push && wr) begin
         if (a[23:21] == 3'd2 && !ws) prot_in[a[2]] = req_data.write_value[7:0];
         if (ws && (a == cbad_pkg::PAD_PORT_A || a == cbad_pkg::PAD_PORT_B)) pad_in = 1'b1;
         if (a == (ws ? cbad_pkg::BOOTSEL_WORD : cbad_pkg::BOOTSEL_BYTE))
            boot_in = ~req_data.write_value[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prot_ff <= '{8'h00, 8'h00};
         pad_ff  <= 1'b0;
         boot_ff <= 1'b0;
      end else begin
         prot_ff <= prot_in;
         pad_ff  <= pad_in;
         boot_ff <= boot_in;
      end
   end

   always_comb begin
      push_entry.req         = req_data;
      push_entry.prot_byte   = prot_ff[a[2]];
      push_entry.pad_present = pad_ff;
      push_entry.boot_mapped = boot_ff;
   end
endmodule

// ----- rtl/cbad_queue.sv -----
// Two-entry queue between front and back end.
// Depends on cbad_pkg.
`timescale 1ns / 1ps
module cbad_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cbad_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output cbad_pkg::entry_type head
);
   cbad_pkg::entry_type mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_entry;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree with count");
endmodule

// ----- rtl/cbad_back.sv -----
// Back end: decodes the queued access and holds the result in an output register.
// Depends on cbad_pkg.
`timescale 1ns / 1ps
module cbad_back #(
   parameter int unsigned BootRomBytes = cbad_pkg::BOOT_ROM_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cbad_pkg::cfg_type   cfg,
   input  logic                q_not_empty,
   input  cbad_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cbad_pkg::rsp_type   rsp_data
);
   localparam logic [23:0] BOOT_LIM = 24'(BootRomBytes);

   logic              valid_ff, valid_in;
   cbad_pkg::rsp_type out_ff, dec;

   assign pop       = q_not_empty && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;
   assign valid_in  = pop || (valid_ff && rsp_stall);

   function automatic cbad_pkg::rsp_type f_open(cbad_pkg::rsp_type r, logic wr, logic ws);
      cbad_pkg::rsp_type o;
      o = r;
      o.target = cbad_pkg::TGT_OPEN;
      o.target_offset = '0;
      o.device_write_data = '0;
      if (!wr) o.open_bus_mask = ws ? 16'hFFFF : 16'h00FF;
      return o;
   endfunction

   function automatic cbad_pkg::rsp_type f_lock(cbad_pkg::rsp_type r, logic wr, logic ws);
      cbad_pkg::rsp_type o;
      o = r;
      o.target = cbad_pkg::TGT_LOCK;
      o.target_offset = '0;
      o.lockup = 1'b1;
      o.device_write_data = '0;
      if (!wr) o.local_data = ws ? 16'hFFFF : 16'h00FF;
      return o;
   endfunction

   function automatic cbad_pkg::rsp_type f_put(cbad_pkg::rsp_type r, cbad_pkg::target_type t,
                                              logic [23:0] off);
      cbad_pkg::rsp_type o;
      o = r;
      o.target = t;
      o.target_offset = off;
      return o;
   endfunction

   always_comb begin
      logic        wr, ws, held, padport, win;
      logic [23:0] a, lim, diff;
      logic [15:0] v;
      logic [7:0]  hb, pg, m;
      logic [4:0]  s;
      logic        bit0;
      cbad_pkg::rsp_type r;

      wr   = head.req.func;
      ws   = head.req.word_size;
      a    = head.req.bus_address;
      held = head.req.z80_bus_held;
      v    = ws ? head.req.write_value : {8'h00, head.req.write_value[7:0]};
      hb   = ws ? v[15:8] : v[7:0];
      pg   = a[15:8];
      m    = a[15:8] & (ws ? 8'h7F : 8'hFF);
      s    = {a[4:2], 2'b00};
      bit0 = ws ? v[8] : v[0];
      padport = (a == cbad_pkg::PAD_PORT_A) || (a == cbad_pkg::PAD_PORT_B);
      lim  = head.boot_mapped ? BOOT_LIM : {1'b0, cfg.cart_rom_bytes};
      win  = cfg.sram_on && a >= cfg.sram_first && a <= cfg.sram_last;
      diff = a - cfg.sram_first;

      r = '0;
      r.target    = cbad_pkg::TGT_OPEN;
      r.byte_lane = ws ? 2'd2 : {1'b0, a[0]};

      unique case (a[23:21])
         3'd0, 3'd1: begin
            if ((!wr && win) || (wr && !(ws && padport) && cfg.sram_writable && win)) begin
               if (cfg.sram_is_eeprom) begin
                  r = f_put(r, cbad_pkg::TGT_EEP, a);
                  r.byte_lane = ws ? 2'd2 : 2'd1;
               end else begin
                  r = f_put(r, cbad_pkg::TGT_SRAM, {8'h00, diff[15:0]});
                  r.byte_lane = ws ? 2'd2 : {1'b0, diff[0]};
               end
               r.device_write_data = v;
            end else if (!wr) begin
               priority if (a < lim) r = f_put(r, cbad_pkg::TGT_ROM, a);
               else if (ws && head.pad_present && padport) r = f_put(r, cbad_pkg::TGT_PAD, '0);
               else if (ws && a == cbad_pkg::CONST1_ADDR) begin
                  r = f_put(r, cbad_pkg::TGT_CONST, '0);
                  r.local_data = 16'h0001;
               end else r = f_put(r, cbad_pkg::TGT_CONST, '0);
            end else if (ws && padport) begin
               r = f_put(r, cbad_pkg::TGT_PAD, '0);
               r.device_write_data = {9'h000, v[0], 6'h00};
               r.pad_reset_pulse = !head.pad_present;
            end else if (cfg.rom_writable) begin
               r = f_put(r, cbad_pkg::TGT_ROM, a);
               r.device_write_data = v;
            end else r = f_open(r, wr, ws);
         end
         3'd2: begin
            if (ws) r = f_open(r, wr, ws);
            else begin
               r = f_put(r, cbad_pkg::TGT_PROT, {23'h0, a[2]});
               if (wr) r.device_write_data = v;
               else r.local_data = {8'h00, head.prot_byte};
            end
         end
         3'd3: r = f_open(r, wr, ws);
         3'd4: r = f_lock(r, wr, ws);
         3'd5: begin
            if (a <= cbad_pkg::ZWIN_LAST) begin
               if (held) r = f_open(r, wr, ws);
               else if (a[14:13] != 2'd3) begin
                  if (a[14]) r = f_put(r, cbad_pkg::TGT_FM, {22'h0, a[1:0]});
                  else r = f_put(r, cbad_pkg::TGT_ZRAM, {11'h0, a[12:0]});
                  if (wr) r.device_write_data = {8'h00, hb};
                  else r.replicate_byte = ws;
               end else if (!wr) begin
                  if (pg == cbad_pkg::ZLOCK_PAGE) r = f_lock(r, wr, ws);
                  else begin
                     r = f_put(r, cbad_pkg::TGT_CONST, '0);
                     r.local_data = ws ? 16'hFFFF : 16'h00FF;
                  end
               end else if (m == 8'h60) begin
                  r = f_put(r, cbad_pkg::TGT_ZBANK, '0);
                  r.device_write_data = {15'h0, hb[0]};
               end else if (m == cbad_pkg::ZLOCK_PAGE) r = f_lock(r, wr, ws);
               else r = f_open(r, wr, ws);
            end else if (a <= cbad_pkg::IO_LAST) begin
               if (wr && !ws && !a[0]) r = f_open(r, wr, ws);
               else begin
                  r = f_put(r, cbad_pkg::TGT_IO, {20'h0, a[4:1]});
                  if (wr) r.device_write_data = {8'h00, v[7:0]};
                  else r.replicate_byte = ws;
               end
            end else if (a <= cbad_pkg::CTRL_LAST) begin
               if (!wr) begin
                  if (a == cbad_pkg::BUSREQ_ADDR) begin
                     r = f_put(r, cbad_pkg::TGT_BUSREQ, '0);
                     r.open_bus_mask = ws ? 16'hFEFF : 16'h00FE;
                     r.replicate_byte = ws;
                  end else if (pg == 8'h00 || pg == 8'h10 || pg == 8'h11 || pg == 8'h12 ||
                               pg == 8'h20 || pg == 8'h30 || pg == 8'h40 || pg == 8'h41 ||
                               pg == 8'h50)
                     r = f_open(r, wr, ws);
                  else r = f_lock(r, wr, ws);
               end else begin
                  unique case (pg)
                     8'h11: begin
                        if (a == cbad_pkg::BUSREQ_ADDR) begin
                           r = f_put(r, cbad_pkg::TGT_BUSREQ, '0);
                           r.device_write_data = {15'h0, bit0};
                        end else r = f_open(r, wr, ws);
                     end
                     8'h12: begin
                        if (a == cbad_pkg::RESET_ADDR) begin
                           r = f_put(r, cbad_pkg::TGT_RESET, '0);
                           r.device_write_data = {15'h0, bit0};
                        end else r = f_open(r, wr, ws);
                     end
                     8'h30: begin
                        if (ws ? (a >= cbad_pkg::ROMBANK_WORD) : ((a[7:0] & 8'hF1) == 8'hF1)) begin
                           r = f_put(r, cbad_pkg::TGT_ROMBANK, {16'h0, a[7:0]});
                           r.device_write_data = v;
                        end else if (a <= cbad_pkg::MULTI_LAST)
                           r = f_put(r, cbad_pkg::TGT_MULTI, {16'h0, a[7:0]});
                        else r = f_open(r, wr, ws);
                     end
                     8'h41: begin
                        if (a == (ws ? cbad_pkg::BOOTSEL_WORD : cbad_pkg::BOOTSEL_BYTE)) begin
                           r = f_put(r, cbad_pkg::TGT_BOOTSEL, '0);
                           r.device_write_data = {15'h0, v[0]};
                        end else r = f_open(r, wr, ws);
                     end
                     8'h10, 8'h20, 8'h40, 8'h50: r = f_open(r, wr, ws);
                     8'h00: begin
                        if (!ws) r = f_open(r, wr, ws);
                        else r = f_lock(r, wr, ws);
                     end
                     default: r = f_lock(r, wr, ws);
                  endcase
               end
            end else r = f_lock(r, wr, ws);
         end
         3'd6: begin
            if ((a & cbad_pkg::VDP_MASK) != cbad_pkg::VDP_MATCH) r = f_lock(r, wr, ws);
            else if (s == 5'h10 || s == 5'h14) begin
               if (!wr) r = f_lock(r, wr, ws);
               else if (ws || a[0]) begin
                  r = f_put(r, cbad_pkg::TGT_PSG, '0);
                  r.device_write_data = {8'h00, v[7:0]};
               end else r = f_open(r, wr, ws);
            end else if (s == 5'h08 || s == 5'h0C) begin
               if (wr) r = f_lock(r, wr, ws);
               else r = f_put(r, cbad_pkg::TGT_HVC, '0);
            end else if (s == 5'h18 || (s == 5'h1C && !wr)) r = f_open(r, wr, ws);
            else begin
               r = f_put(r, (s == 5'h00) ? cbad_pkg::TGT_VDATA :
                            ((s == 5'h04) ? cbad_pkg::TGT_VCTRL : cbad_pkg::TGT_VTEST), '0);
               if (wr) begin
                  r.device_write_data = ws ? v : {v[7:0], v[7:0]};
                  r.byte_lane = 2'd2;
               end else if (s == 5'h04 && (ws || !a[0]))
                  r.open_bus_mask = ws ? 16'hFC00 : 16'h00FC;
            end
         end
         default: begin
            r = f_put(r, cbad_pkg::TGT_WRAM, {8'h00, a[15:0]});
            r.device_write_data = v;
         end
      endcase

      // drop the fields that do not apply to this direction
      if (wr) begin
         r.replicate_byte = 1'b0;
         r.open_bus_mask  = '0;
         r.local_data     = '0;
      end else r.device_write_data = '0;
      dec = r;
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= dec;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(out_ff)))
      else $error("result changed while stalled");
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!valid_ff || !rsp_stall))
      else $error("pop without a free output slot");
   a_lock_tgt: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (out_ff.lockup == (out_ff.target == cbad_pkg::TGT_LOCK)))
      else $error("lockup flag disagrees with target");
endmodule

// ----- rtl/console_bus_address_decoder.sv -----
// Path: an accepted access is written into the queue, then decoded from the queue head into
// the output register; while an earlier beat waits there on rsp_stall, later beats stay queued.
// Throughput: one access per cycle; the front end stalls only when the 2-entry queue is full.
// Decode is compare-and-mask logic in the back end, registered once at the output.
// Reset (synchronous, active high): protection bytes, pad detect and boot-map flag clear,
// configuration returns to its defaults, queue and output register empty.
// Top level: config registers, front end, queue and back end. Depends on cbad_pkg.
`timescale 1ns / 1ps
module console_bus_address_decoder #(
   parameter int unsigned BootRomBytes = cbad_pkg::BOOT_ROM_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cbad_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cbad_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [cbad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbad_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   cbad_pkg::cfg_type   cfg_ff, cfg_in;
   cbad_pkg::entry_type push_entry, head;
   logic                push, pop, q_full, q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cbad_pkg::csr_index_type'(csr_index))
            cbad_pkg::CSR_SRAM_ON:        cfg_in.sram_on        = csr_wdata[0];
            cbad_pkg::CSR_SRAM_WRITABLE:  cfg_in.sram_writable  = csr_wdata[0];
            cbad_pkg::CSR_SRAM_IS_EEPROM: cfg_in.sram_is_eeprom = csr_wdata[0];
            cbad_pkg::CSR_SRAM_FIRST:     cfg_in.sram_first     = csr_wdata;
            cbad_pkg::CSR_SRAM_LAST:      cfg_in.sram_last      = csr_wdata;
            cbad_pkg::CSR_CART_ROM_BYTES: cfg_in.cart_rom_bytes = csr_wdata[22:0];
            cbad_pkg::CSR_ROM_WRITABLE:   cfg_in.rom_writable   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sram_on        <= 1'b0;
         cfg_ff.sram_writable  <= 1'b0;
         cfg_ff.sram_is_eeprom <= 1'b0;
         cfg_ff.sram_first     <= 24'h200000;
         cfg_ff.sram_last      <= 24'h20FFFF;
         cfg_ff.cart_rom_bytes <= 23'h400000;
         cfg_ff.rom_writable   <= 1'b0;
      end else cfg_ff <= cfg_in;
   end

   cbad_front u_front (
      .clock, .reset, .req_valid, .req_data, .q_full, .req_stall, .push, .push_entry
   );

   cbad_queue u_queue (
      .clock, .reset, .push, .push_entry, .pop, .full(q_full), .not_empty(q_not_empty), .head
   );

   cbad_back #(.BootRomBytes(BootRomBytes)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_not_empty, .head, .pop, .rsp_valid, .rsp_stall,
      .rsp_data
   );
endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for console_bus_address_decoder: directed and random bus accesses
// under several memory-map settings, checked beat by beat against an in-bench decoder.
// Depends on rtl/cbad_pkg.sv and rtl/console_bus_address_decoder.sv.
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned BOOT_BYTES = 2048;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   cbad_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   cbad_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [cbad_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cbad_pkg::CSR_DATA_W-1:0] csr_wdata;

   console_bus_address_decoder #(.BootRomBytes(BOOT_BYTES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // memory-map settings and decoder state as the bench sees them
   logic        map_sram_on, map_sram_wr, map_sram_eep, map_rom_wr;
   logic [23:0] map_first, map_last, map_rom_bytes;
   logic [7:0]  prot_latch [2];
   logic        pad_seen, boot_mapped;

   cbad_pkg::req_type pending_accesses[$];
   cbad_pkg::rsp_type expected_decodes[$];
   int      mismatches = 0;
   logic    req_taken;
   int      gap_left, burst_left;
   int      stall_left = 0;
   int      stall_mode = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic cbad_pkg::rsp_type mk_open(cbad_pkg::rsp_type r, logic wr, logic ws);
      r.target = cbad_pkg::TGT_OPEN;
      r.target_offset = '0;
      r.device_write_data = '0;
      if (!wr) r.open_bus_mask = ws ? 16'hFFFF : 16'h00FF;
      return r;
   endfunction

   function automatic cbad_pkg::rsp_type mk_lock(cbad_pkg::rsp_type r, logic wr, logic ws);
      r.target = cbad_pkg::TGT_LOCK;
      r.target_offset = '0;
      r.lockup = 1'b1;
      r.device_write_data = '0;
      if (!wr) r.local_data = ws ? 16'hFFFF : 16'h00FF;
      return r;
   endfunction

   function automatic cbad_pkg::rsp_type mk_const(cbad_pkg::rsp_type r, logic [15:0] v);
      r.target = cbad_pkg::TGT_CONST;
      r.target_offset = '0;
      r.local_data = v;
      return r;
   endfunction

   function automatic cbad_pkg::rsp_type mk_backup(cbad_pkg::rsp_type r, logic [23:0] a,
                                                   logic ws, logic [15:0] v);
      if (map_sram_eep) begin
         r.target = cbad_pkg::TGT_EEP;
         r.target_offset = a;
         r.byte_lane = ws ? 2'd2 : 2'd1;
      end else begin
         r.target = cbad_pkg::TGT_SRAM;
         r.target_offset = {8'h00, 16'(a - map_first)};
         r.byte_lane = ws ? 2'd2 : {1'b0, r.target_offset[0]};
      end
      r.device_write_data = v;
      return r;
   endfunction

   // Decode one access and advance the latch, pad and boot state it touches.
   function automatic cbad_pkg::rsp_type decode_access(cbad_pkg::req_type q);
      cbad_pkg::rsp_type r;
      logic wr, ws, held, padport, in_win;
      logic [23:0] a, lim;
      logic [15:0] v, m;
      logic [7:0] hb, pg;
      logic bitv;
      logic [4:0] s;
      r = '0;
      wr = q.func;
      ws = q.word_size;
      a = q.bus_address;
      held = q.z80_bus_held;
      v = ws ? q.write_value : {8'h00, q.write_value[7:0]};
      r.byte_lane = ws ? 2'd2 : {1'b0, a[0]};
      in_win = map_sram_on && a >= map_first && a <= map_last;
      case (a[23:21])
         3'd0, 3'd1: begin
            padport = (a == cbad_pkg::PAD_PORT_A) || (a == cbad_pkg::PAD_PORT_B);
            lim = boot_mapped ? 24'(BOOT_BYTES) : map_rom_bytes;
            if (!wr) begin
               if (in_win) r = mk_backup(r, a, ws, 16'h0);
               else if (a < lim) begin
                  r.target = cbad_pkg::TGT_ROM; r.target_offset = a;
               end else if (ws && pad_seen && padport) r.target = cbad_pkg::TGT_PAD;
               else if (ws && a == cbad_pkg::CONST1_ADDR) r = mk_const(r, 16'h1);
               else r = mk_const(r, 16'h0);
            end else if (ws && padport) begin
               r.target = cbad_pkg::TGT_PAD;
               r.device_write_data = {9'h0, v[0], 6'h0};
               r.pad_reset_pulse = !pad_seen;
               pad_seen = 1'b1;
            end else if (map_sram_wr && in_win) r = mk_backup(r, a, ws, v);
            else if (map_rom_wr) begin
               r.target = cbad_pkg::TGT_ROM; r.target_offset = a; r.device_write_data = v;
            end else r = mk_open(r, wr, ws);
         end
         3'd2: begin
            if (ws) r = mk_open(r, wr, ws);
            else begin
               r.target = cbad_pkg::TGT_PROT;
               r.target_offset = {23'h0, a[2]};
               if (wr) begin
                  prot_latch[a[2]] = v[7:0];
                  r.device_write_data = v;
               end else r.local_data = {8'h00, prot_latch[a[2]]};
            end
         end
         3'd3: r = mk_open(r, wr, ws);
         3'd4: r = mk_lock(r, wr, ws);
         3'd5: begin
            if (a <= cbad_pkg::ZWIN_LAST) begin
               hb = ws ? v[15:8] : v[7:0];
               if (held) r = mk_open(r, wr, ws);
               else if (a[14:13] == 2'd3) begin
                  if (!wr) begin
                     if (a[15:8] == cbad_pkg::ZLOCK_PAGE) r = mk_lock(r, wr, ws);
                     else r = mk_const(r, ws ? 16'hFFFF : 16'h00FF);
                  end else begin
                     m = a[15:0] & (ws ? 16'h7F00 : 16'hFF00);
                     if (m == 16'h6000) begin
                        r.target = cbad_pkg::TGT_ZBANK; r.device_write_data = {15'h0, hb[0]};
                     end else if (m == 16'h7F00) r = mk_lock(r, wr, ws);
                     else r = mk_open(r, wr, ws);
                  end
               end else begin
                  if (a[14]) begin
                     r.target = cbad_pkg::TGT_FM; r.target_offset = {22'h0, a[1:0]};
                  end else begin
                     r.target = cbad_pkg::TGT_ZRAM; r.target_offset = {11'h0, a[12:0]};
                  end
                  if (wr) r.device_write_data = {8'h00, hb};
                  else r.replicate_byte = ws;
               end
            end else if (a <= cbad_pkg::IO_LAST) begin
               if (wr && !ws && !a[0]) r = mk_open(r, wr, ws);
               else begin
                  r.target = cbad_pkg::TGT_IO;
                  r.target_offset = {20'h0, a[4:1]};
                  if (wr) r.device_write_data = {8'h00, v[7:0]};
                  else r.replicate_byte = ws;
               end
            end else if (a <= cbad_pkg::CTRL_LAST) begin
               pg = a[15:8];
               bitv = ws ? v[8] : v[0];
               if (!wr) begin
                  if (a == cbad_pkg::BUSREQ_ADDR) begin
                     r.target = cbad_pkg::TGT_BUSREQ;
                     r.open_bus_mask = ws ? 16'hFEFF : 16'h00FE;
                     r.replicate_byte = ws;
                  end else if (pg inside {8'h00, 8'h10, 8'h11, 8'h12, 8'h20, 8'h30,
                                          8'h40, 8'h41, 8'h50})
                     r = mk_open(r, wr, ws);
                  else r = mk_lock(r, wr, ws);
               end else begin
                  case (pg)
                     8'h11:
                        if (a == cbad_pkg::BUSREQ_ADDR) begin
                           r.target = cbad_pkg::TGT_BUSREQ;
                           r.device_write_data = {15'h0, bitv};
                        end else r = mk_open(r, wr, ws);
                     8'h12:
                        if (a == cbad_pkg::RESET_ADDR) begin
                           r.target = cbad_pkg::TGT_RESET;
                           r.device_write_data = {15'h0, bitv};
                        end else r = mk_open(r, wr, ws);
                     8'h30:
                        if (ws ? (a >= cbad_pkg::ROMBANK_WORD)
                               : ((a[7:0] & 8'hF1) == 8'hF1)) begin
                           r.target = cbad_pkg::TGT_ROMBANK;
                           r.target_offset = {16'h0, a[7:0]};
                           r.device_write_data = v;
                        end else if (a <= cbad_pkg::MULTI_LAST) begin
                           r.target = cbad_pkg::TGT_MULTI;
                           r.target_offset = {16'h0, a[7:0]};
                        end else r = mk_open(r, wr, ws);
                     8'h41:
                        if (a == (ws ? cbad_pkg::BOOTSEL_WORD : cbad_pkg::BOOTSEL_BYTE)) begin
                           r.target = cbad_pkg::TGT_BOOTSEL;
                           r.device_write_data = {15'h0, v[0]};
                           boot_mapped = !v[0];
                        end else r = mk_open(r, wr, ws);
                     8'h10, 8'h20, 8'h40, 8'h50: r = mk_open(r, wr, ws);
                     8'h00: r = ws ? mk_lock(r, wr, ws) : mk_open(r, wr, ws);
                     default: r = mk_lock(r, wr, ws);
                  endcase
               end
            end else r = mk_lock(r, wr, ws);
         end
         3'd6: begin
            s = a[4:0] & 5'h1C;
            if ((a & cbad_pkg::VDP_MASK) != cbad_pkg::VDP_MATCH) r = mk_lock(r, wr, ws);
            else if (s == 5'h10 || s == 5'h14) begin
               if (!wr) r = mk_lock(r, wr, ws);
               else if (ws || a[0]) begin
                  r.target = cbad_pkg::TGT_PSG; r.device_write_data = {8'h00, v[7:0]};
               end else r = mk_open(r, wr, ws);
            end else if (s == 5'h08 || s == 5'h0C) begin
               if (wr) r = mk_lock(r, wr, ws);
               else r.target = cbad_pkg::TGT_HVC;
            end else if (s == 5'h18 || (s == 5'h1C && !wr)) r = mk_open(r, wr, ws);
            else begin
               r.target = (s == 5'h00) ? cbad_pkg::TGT_VDATA :
                          ((s == 5'h04) ? cbad_pkg::TGT_VCTRL : cbad_pkg::TGT_VTEST);
               if (wr) begin
                  r.device_write_data = ws ? v : {v[7:0], v[7:0]};
                  r.byte_lane = 2'd2;
               end else if (s == 5'h04 && (ws || !a[0]))
                  r.open_bus_mask = ws ? 16'hFC00 : 16'h00FC;
            end
         end
         default: begin
            r.target = cbad_pkg::TGT_WRAM;
            r.target_offset = {8'h00, a[15:0]};
            if (wr) r.device_write_data = v;
         end
      endcase
      if (wr) begin
         r.replicate_byte = 1'b0;
         r.open_bus_mask = '0;
         r.local_data = '0;
      end else r.device_write_data = '0;
      return r;
   endfunction

   task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      cbad_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_decodes.size() == 0) begin
               $display("%0t: unexpected beat, expected none got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_decodes.pop_front();
               check_field("target", 24'(want.target), 24'(rsp_data.target));
               check_field("target_offset", want.target_offset, rsp_data.target_offset);
               check_field("byte_lane", 24'(want.byte_lane), 24'(rsp_data.byte_lane));
               check_field("replicate_byte", 24'(want.replicate_byte),
                           24'(rsp_data.replicate_byte));
               check_field("open_bus_mask", 24'(want.open_bus_mask),
                           24'(rsp_data.open_bus_mask));
               check_field("local_data", 24'(want.local_data), 24'(rsp_data.local_data));
               check_field("device_write_data", 24'(want.device_write_data),
                           24'(rsp_data.device_write_data));
               check_field("lockup", 24'(want.lockup), 24'(rsp_data.lockup));
               check_field("pad_reset_pulse", 24'(want.pad_reset_pulse),
                           24'(rsp_data.pad_reset_pulse));
            end
         end
         if (req_valid && !req_stall) begin
            expected_decodes.push_back(decode_access(req_data));
            req_taken <= 1'b1;
         end else begin
            req_taken <= 1'b0;
         end
      end
   end

   // driver: bursts of beats with random gaps, changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         burst_left <= 4;
      end else if (req_valid && !req_taken) begin
         // hold the stalled beat
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_accesses.size() != 0) begin
         req_valid <= 1'b1;
         req_data <= pending_accesses.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall pattern: free runs, light stalls and heavy stalls
   always @(negedge clock) begin
      if (stall_left <= 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 4) != 0);
      endcase
   end

   task automatic write_csr(cbad_pkg::csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic set_map(logic on, logic wr, logic eep, logic [23:0] first,
                          logic [23:0] last, logic [22:0] rom, logic romwr);
      write_csr(cbad_pkg::CSR_SRAM_ON, {23'h0, on});
      write_csr(cbad_pkg::CSR_SRAM_WRITABLE, {23'h0, wr});
      write_csr(cbad_pkg::CSR_SRAM_IS_EEPROM, {23'h0, eep});
      write_csr(cbad_pkg::CSR_SRAM_FIRST, first);
      write_csr(cbad_pkg::CSR_SRAM_LAST, last);
      write_csr(cbad_pkg::CSR_CART_ROM_BYTES, {1'b0, rom});
      write_csr(cbad_pkg::CSR_ROM_WRITABLE, {23'h0, romwr});
      @(negedge clock);
      csr_we <= 1'b0;
      map_sram_on = on;
      map_sram_wr = wr;
      map_sram_eep = eep;
      map_first = first;
      map_last = last;
      map_rom_bytes = {1'b0, rom};
      map_rom_wr = romwr;
   endtask

   function automatic cbad_pkg::req_type make_access(logic wr, logic ws, logic [23:0] a,
                                                     logic [15:0] v, logic held);
      cbad_pkg::req_type q;
      q.func = wr;
      q.word_size = ws;
      q.bus_address = a;
      q.write_value = v;
      q.z80_bus_held = held;
      return q;
   endfunction

   function automatic cbad_pkg::req_type random_access();
      logic [23:0] a;
      logic [23:0] hot [12] = '{cbad_pkg::PAD_PORT_A, cbad_pkg::PAD_PORT_B,
                                cbad_pkg::CONST1_ADDR, cbad_pkg::BUSREQ_ADDR,
                                cbad_pkg::RESET_ADDR, cbad_pkg::BOOTSEL_WORD,
                                cbad_pkg::BOOTSEL_BYTE, cbad_pkg::ROMBANK_WORD,
                                cbad_pkg::MULTI_LAST, 24'hA07F00, 24'hA06000, 24'h0007FF};
      logic [7:0] pages [10] = '{8'h00, 8'h10, 8'h11, 8'h12, 8'h20, 8'h30, 8'h40,
                                 8'h41, 8'h50, 8'h77};
      case ($urandom_range(0, 9))
         0: a = 24'($urandom);
         1: a = 24'($urandom_range(0, 24'h3FFFFF));
         2: a = map_first + 24'($urandom_range(0, 8)) - 24'd4;
         3: a = hot[$urandom_range(0, 11)] + 24'($urandom_range(0, 1));
         4: a = 24'hA00000 | 24'($urandom_range(0, 16'hFFFF));
         5: a = 24'hA10000 | 24'($urandom_range(0, 8'h3F));
         6: a = {8'hA1, pages[$urandom_range(0, 9)], 8'($urandom)};
         7: a = ($urandom_range(0, 3) == 0) ? 24'($urandom) | 24'hC00000
                                              : 24'hC00000 | 24'($urandom_range(0, 31));
         8: a = 24'h400000 | 24'($urandom_range(0, 7));
         default: a = 24'hE00000 | 24'($urandom);
      endcase
      return make_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), a,
                         16'($urandom), $urandom_range(0, 3) == 0);
   endfunction

   task automatic drain();
      do begin
         @(negedge clock);
         #1;
      end while (pending_accesses.size() != 0 || req_valid || expected_decodes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count) pending_accesses.push_back(random_access());
      drain();
   endtask

   initial begin
      logic [23:0] f;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = cbad_pkg::CSR_UNUSED;
      csr_wdata = '0;
      map_sram_on = 1'b0; map_sram_wr = 1'b0; map_sram_eep = 1'b0; map_rom_wr = 1'b0;
      map_first = 24'h200000; map_last = 24'h20FFFF; map_rom_bytes = 24'h400000;
      prot_latch[0] = 8'h00; prot_latch[1] = 8'h00;
      pad_seen = 1'b0;
      boot_mapped = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_map(1'b1, 1'b1, 1'b0, 24'h200000, 24'h20FFFF, 23'h400000, 1'b0);
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'h000000, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'h200001, 16'hFFFF, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, cbad_pkg::PAD_PORT_A, 16'h0000,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b1, cbad_pkg::PAD_PORT_A, 16'h0001,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b1, cbad_pkg::PAD_PORT_B, 16'hFFFE,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, cbad_pkg::PAD_PORT_B, 16'h0000,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, cbad_pkg::CONST1_ADDR, 16'h0000,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'h400004, 16'h00A5, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b0, 24'h400005, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b0, 24'hA00000, 16'h0000, 1'b1));
      pending_accesses.push_back(make_access(1'b1, 1'b1, 24'hA04001, 16'h1234, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hA06000, 16'h00FF, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'hA07F00, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'hA10003, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hA10002, 16'h0055, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, cbad_pkg::BUSREQ_ADDR, 16'h0000,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b1, cbad_pkg::RESET_ADDR, 16'h0100,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hA130F1, 16'h0007, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hA13000, 16'h0003, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b1, cbad_pkg::BOOTSEL_WORD, 16'h0000,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'h000900, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, cbad_pkg::BOOTSEL_BYTE, 16'h0001,
                                             1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hC00000, 16'h00C3, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b0, 24'hC00004, 16'h0000, 1'b0));
      pending_accesses.push_back(make_access(1'b1, 1'b0, 24'hC00011, 16'h009F, 1'b0));
      pending_accesses.push_back(make_access(1'b0, 1'b1, 24'hC00008, 16'h0000, 1'b0));
      drain();
      random_phase(80);

      set_map(1'b1, 1'b0, 1'b1, 24'h200001, 24'h3FFFFF, 23'h500000, 1'b1);
      random_phase(80);
      set_map(1'b0, 1'b1, 1'b0, 24'h000000, 24'hFFFFFF, 23'h000000, 1'b0);
      random_phase(70);
      set_map(1'b1, 1'b1, 1'b1, 24'h000000, 24'hFFFFFF, 23'h500000, 1'b1);
      random_phase(70);
      set_map(1'b1, 1'b1, 1'b0, 24'hFFFFFF, 24'h000000, 23'h7FFFFF, 1'b0);
      random_phase(30);
      f = 24'($urandom_range(0, 24'h3FFFFF));
      set_map(1'b1, 1'b1, 1'b0, f, f + 24'($urandom_range(0, 16'hFFFF)),
              23'($urandom_range(0, 5242880)), 1'b1);
      random_phase(70);

      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
